// ----- hw/rtl/median_3x3_filter_macros.svh -----
// Assertion macros used by the checker file of the median filter.
`ifndef MEDIAN_3X3_FILTER_MACROS_SVH
`define MEDIAN_3X3_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define MF3_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define MF3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mf3_pkg.sv -----
`default_nettype none
package mf3_pkg;

   // Default and widest pixel width
   localparam int PIXEL_BITS_DEF = 8;
   localparam int PIX_MAX_BITS   = 16;

   typedef logic [PIX_MAX_BITS-1:0] mf3_pix_type;

   // Columns held for the open row
   typedef enum logic [2:0] {
      HELD_NONE = 3'b001,
      HELD_ONE  = 3'b010,
      HELD_TWO  = 3'b100
   } mf3_held_type;

   // Control that travels with a window through the stages
   typedef struct packed {
      logic valid;
      logic done;
   } mf3_tag_type;

   function automatic mf3_pix_type min2(input mf3_pix_type a, input mf3_pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3_pix_type max2(input mf3_pix_type a, input mf3_pix_type b);
      return (a > b) ? a : b;
   endfunction

   // Median of three values
   function automatic mf3_pix_type mid3(input mf3_pix_type a, input mf3_pix_type b,
                                        input mf3_pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mf3_lane.sv -----
`default_nettype none
// Sort one window column: smallest, middle and largest of its three pixels.
module mf3_lane #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
   input  wire logic [3*PIXEL_BITS-1:0] column,
   output logic      [PIXEL_BITS-1:0]   pix_lo,
   output logic      [PIXEL_BITS-1:0]   pix_mid,
   output logic      [PIXEL_BITS-1:0]   pix_hi
);

   mf3_pkg::mf3_pix_type p, q, r;

   assign p = mf3_pkg::mf3_pix_type'(column[PIXEL_BITS-1:0]);
   assign q = mf3_pkg::mf3_pix_type'(column[2*PIXEL_BITS-1:PIXEL_BITS]);
   assign r = mf3_pkg::mf3_pix_type'(column[3*PIXEL_BITS-1:2*PIXEL_BITS]);

   assign pix_lo  = PIXEL_BITS'(mf3_pkg::min2(p, mf3_pkg::min2(q, r)));
   assign pix_hi  = PIXEL_BITS'(mf3_pkg::max2(p, mf3_pkg::max2(q, r)));
   assign pix_mid = PIXEL_BITS'(mf3_pkg::mid3(p, q, r));

endmodule
`default_nettype wire

// ----- hw/rtl/mf3_merge.sv -----
`default_nettype none
// Combine the three sorted columns into the nine-pixel median.
module mf3_merge #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
   input  wire logic [2:0][PIXEL_BITS-1:0] lane_lo,
   input  wire logic [2:0][PIXEL_BITS-1:0] lane_mid,
   input  wire logic [2:0][PIXEL_BITS-1:0] lane_hi,
   output logic           [PIXEL_BITS-1:0] median
);

   mf3_pkg::mf3_pix_type lo_max, hi_min, mid_mid;

   // Largest minimum, smallest maximum, median of medians
   always_comb begin
      lo_max  = mf3_pkg::max2(mf3_pkg::max2(mf3_pkg::mf3_pix_type'(lane_lo[0]),
                                            mf3_pkg::mf3_pix_type'(lane_lo[1])),
                              mf3_pkg::mf3_pix_type'(lane_lo[2]));
      hi_min  = mf3_pkg::min2(mf3_pkg::min2(mf3_pkg::mf3_pix_type'(lane_hi[0]),
                                            mf3_pkg::mf3_pix_type'(lane_hi[1])),
                              mf3_pkg::mf3_pix_type'(lane_hi[2]));
      mid_mid = mf3_pkg::mid3(mf3_pkg::mf3_pix_type'(lane_mid[0]),
                              mf3_pkg::mf3_pix_type'(lane_mid[1]),
                              mf3_pkg::mf3_pix_type'(lane_mid[2]));
   end

   assign median = PIXEL_BITS'(mf3_pkg::mid3(lo_max, mid_mid, hi_min));

endmodule
`default_nettype wire

// ----- hw/rtl/mf3_ctrl.sv -----
`default_nettype none
// Column history and window issue. Each accepted column yields zero, one or
// two windows; a second window (row end) waits in a one-entry hold register.
module mf3_ctrl #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [3*PIXEL_BITS-1:0] in_column,
   input  wire logic                    in_first,
   input  wire logic                    in_last,
   output mf3_pkg::mf3_tag_type         win_tag,
   output logic      [3*PIXEL_BITS-1:0] win_left,
   output logic      [3*PIXEL_BITS-1:0] win_mid,
   output logic      [3*PIXEL_BITS-1:0] win_right,
   input  wire logic                    win_ready
);

   localparam int COL_BITS = 3 * PIXEL_BITS;

   mf3_pkg::mf3_held_type held_ff, held_in;
   logic [COL_BITS-1:0]   left_ff, left_in, middle_ff, middle_in;

   mf3_pkg::mf3_tag_type  tag_ff, tag_in, pend_tag_ff, pend_tag_in;
   logic [COL_BITS-1:0]   wl_ff, wl_in, wm_ff, wm_in, wr_ff, wr_in;
   logic [COL_BITS-1:0]   pl_ff, pl_in, pm_ff, pm_in;

   logic                  stage_ready, accept, restart;
   logic                  j1_valid, j1_done, j2_valid;
   logic [COL_BITS-1:0]   j1_l, j1_m, j1_r;

   assign stage_ready = !tag_ff.valid || win_ready;
   assign in_ready    = stage_ready && !pend_tag_ff.valid;
   assign accept      = in_valid && in_ready;
   assign restart     = in_first || (held_ff == mf3_pkg::HELD_NONE);

   // Update the column history and form the windows of this transaction
   always_comb begin
      held_in   = held_ff;
      left_in   = left_ff;
      middle_in = middle_ff;
      j1_valid  = 1'b0;
      j1_done   = 1'b0;
      j1_l      = in_column;
      j1_m      = in_column;
      j1_r      = in_column;
      j2_valid  = 1'b0;
      if (accept) begin
         if (restart) begin
            if (in_last) begin
               // one-column row: the column is its own neighbor on both sides
               j1_valid = 1'b1;
               j1_done  = 1'b1;
               held_in  = mf3_pkg::HELD_NONE;
            end else begin
               middle_in = in_column;
               held_in   = mf3_pkg::HELD_ONE;
            end
         end else begin
            j1_valid = 1'b1;
            case (held_ff)
               mf3_pkg::HELD_ONE: j1_l = in_column;   // mirror at the left edge
               default:           j1_l = left_ff;
            endcase
            j1_m      = middle_ff;
            left_in   = middle_ff;
            middle_in = in_column;
            held_in   = mf3_pkg::HELD_TWO;
            if (in_last) begin
               j2_valid = 1'b1;
               held_in  = mf3_pkg::HELD_NONE;
            end
         end
      end
   end

   // Advance the window register, taking the held window first
   always_comb begin
      tag_in      = tag_ff;
      wl_in       = wl_ff;
      wm_in       = wm_ff;
      wr_in       = wr_ff;
      pend_tag_in = pend_tag_ff;
      pl_in       = pl_ff;
      pm_in       = pm_ff;
      if (stage_ready) begin
         if (pend_tag_ff.valid) begin
            tag_in            = pend_tag_ff;
            wl_in             = pl_ff;
            wm_in             = pm_ff;
            wr_in             = pl_ff;
            pend_tag_in.valid = 1'b0;
         end else begin
            tag_in.valid = j1_valid;
            tag_in.done  = j1_done;
            wl_in        = j1_l;
            wm_in        = j1_m;
            wr_in        = j1_r;
         end
      end
      // last column: its right neighbor mirrors back to the previous column
      if (j2_valid) begin
         pend_tag_in.valid = 1'b1;
         pend_tag_in.done  = 1'b1;
         pl_in             = middle_ff;
         pm_in             = in_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= mf3_pkg::HELD_NONE;
         tag_ff      <= '0;
         pend_tag_ff <= '0;
      end else begin
         held_ff     <= held_in;
         tag_ff      <= tag_in;
         pend_tag_ff <= pend_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      middle_ff <= middle_in;
      wl_ff     <= wl_in;
      wm_ff     <= wm_in;
      wr_ff     <= wr_in;
      pl_ff     <= pl_in;
      pm_ff     <= pm_in;
   end

   assign win_tag   = tag_ff;
   assign win_left  = wl_ff;
   assign win_mid   = wm_ff;
   assign win_right = wr_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/median_3x3_filter.sv -----
`default_nettype none
// Channel  Dir  Transaction                  tdata (low bit up)    side
// req_*    in   one window column of a row   above, center, below  tuser=first, tlast=last
// rsp_*    out  one median result            median_pixel          tlast=row_done
//
// One column per cycle is taken while the output is not stalled; a row's last
// column gives two results and holds req_tready low while the second window is issued.
// A column reaches the result it completes through the window register, the three
// sorting lanes into their result register, and the merge into the output register.
// Reset (synchronous) closes any open row and empties all stages.
// A stall on rsp_tready fills the three stages before req_tready drops.
module median_3x3_filter #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // pixel_above, pixel_center, pixel_below, zero fill
   input  wire logic [((3*PIXEL_BITS+7)/8)*8-1:0] req_tdata,
   // first_of_row
   input  wire logic                          req_tuser,
   input  wire logic                          req_tlast,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // median_pixel, zero fill
   output logic      [((PIXEL_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int COL_BITS      = 3 * PIXEL_BITS;
   localparam int RSP_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

   mf3_pkg::mf3_tag_type             win_tag;
   logic [2:0][COL_BITS-1:0]         win_cols;
   logic                             s1_ready, s2_ready;

   logic [2:0][PIXEL_BITS-1:0]       lane_lo, lane_mid, lane_hi;
   logic [2:0][PIXEL_BITS-1:0]       lo_ff, mid_ff, hi_ff;
   mf3_pkg::mf3_tag_type             s1_tag_ff, s1_tag_in;
   logic [PIXEL_BITS-1:0]            median;

   logic                             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [PIXEL_BITS-1:0]            rsp_pix_ff, rsp_pix_in;

   mf3_ctrl #(.PIXEL_BITS(PIXEL_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_column (req_tdata[COL_BITS-1:0]),
      .in_first  (req_tuser),
      .in_last   (req_tlast),
      .win_tag   (win_tag),
      .win_left  (win_cols[0]),
      .win_mid   (win_cols[1]),
      .win_right (win_cols[2]),
      .win_ready (s1_ready)
   );

   // One sorting lane per window column
   for (genvar g = 0; g < 3; g++) begin : g_lane
      mf3_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
         .column  (win_cols[g]),
         .pix_lo  (lane_lo[g]),
         .pix_mid (lane_mid[g]),
         .pix_hi  (lane_hi[g])
      );
   end

   assign s2_ready = !rsp_valid_ff || rsp_tready;
   assign s1_ready = !s1_tag_ff.valid || s2_ready;

   // Hold or advance the lane results
   always_comb begin
      s1_tag_in = s1_ready ? win_tag : s1_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         lo_ff  <= lane_lo;
         mid_ff <= lane_mid;
         hi_ff  <= lane_hi;
      end
   end

   mf3_merge #(.PIXEL_BITS(PIXEL_BITS)) u_merge (
      .lane_lo  (lo_ff),
      .lane_mid (mid_ff),
      .lane_hi  (hi_ff),
      .median   (median)
   );

   // Output register: load when empty or when the current transaction leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_pix_in   = rsp_pix_ff;
      if (s2_ready) begin
         rsp_valid_in = s1_tag_ff.valid;
         rsp_last_in  = s1_tag_ff.done;
         rsp_pix_in   = median;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_tag_ff    <= s1_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff <= rsp_last_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_pix_ff);

endmodule
`default_nettype wire

// ----- hw/rtl/mf3_checker.sv -----
`default_nettype none
`include "median_3x3_filter_macros.svh"
// Port-level checks of the median filter.
module mf3_checker #(
   parameter int RSP_DATA_BITS = ((mf3_pkg::PIXEL_BITS_DEF + 7) / 8) * 8
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     req_tuser,
   input wire logic                     req_tlast,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                     rsp_tlast
);

   logic       req_take, rsp_take;
   logic       open_ff, open_in;
   logic [2:0] owed_ff, owed_in, jobs;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // Track whether a row is open and how many results are owed
   always_comb begin
      jobs    = 3'd0;
      open_in = open_ff;
      if (req_take) begin
         if (req_tuser || !open_ff) begin
            jobs = req_tlast ? 3'd1 : 3'd0;
         end else begin
            jobs = req_tlast ? 3'd2 : 3'd1;
         end
         open_in = !req_tlast;
      end
      owed_in = owed_ff + jobs - (rsp_take ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         owed_ff <= '0;
      end else begin
         open_ff <= open_in;
         owed_ff <= owed_in;
      end
   end

   `MF3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   `MF3_ASSERT_NOW(a_no_extra, clock, reset, rsp_tvalid, owed_ff != 3'd0,
      "result with no column owing one")

   `MF3_ASSERT_NEXT(a_row_end_gap, clock, reset, req_take && req_tlast && open_ff && !req_tuser,
      !req_tready, "row end did not pause input for its second window")

endmodule

bind median_3x3_filter mf3_checker #(.RSP_DATA_BITS(RSP_DATA_BITS)) u_mf3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
